/* rtl/bwfpa_pkg.sv */
// shared types and constants of the best/worst fit page allocator
package bwfpa_pkg;

	localparam int unsigned KB_PER_PAGE_SHIFT = 2;
	localparam int unsigned KB_ROUND = 3;
	localparam int unsigned MAX_REQ_PAGES = 128;
	localparam int unsigned NEED_W = 9;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_KILL = 2'd1;

	localparam logic [2:0] ST_ADDED = 3'd0;
	localparam logic [2:0] ST_RUNNING = 3'd1;
	localparam logic [2:0] ST_NO_MEM = 3'd2;
	localparam logic [2:0] ST_KILLED = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_QUERY = 3'd5;
	localparam logic [2:0] ST_ZERO_SIZE = 3'd6;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] program_id;
		logic [9:0] size_kb;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [8:0] page_count;
		logic [4:0] first_page;
		logic [4:0] free_fragments;
	} result_t;

	typedef struct packed {
		logic clr;
		logic step;
		logic free;
	} scan_ctl_t;

endpackage

/* rtl/bwfpa_ram.sv */
// generic single write port ram with registered read
module bwfpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/bwfpa_scan.sv */
// free run tracker: fragment count and best or worst fitting run, one page a step
module bwfpa_scan #(
	parameter int TOTAL_PAGES = 32
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  bwfpa_pkg::scan_ctl_t                     ctl,
	input  logic [$clog2(TOTAL_PAGES)-1:0]           page,
	input  logic [bwfpa_pkg::NEED_W-1:0]             need,
	input  logic                                     best_fit,
	output logic [$clog2(TOTAL_PAGES+1)-1:0]         frag,
	output logic                                     found,
	output logic [$clog2(TOTAL_PAGES)-1:0]           best_start,
	output logic [$clog2(TOTAL_PAGES+1)-1:0]         best_len
);

	import bwfpa_pkg::*;

	localparam int IW = $clog2(TOTAL_PAGES);
	localparam int AW = $clog2(TOTAL_PAGES + 1);
	localparam int CW = (AW > NEED_W) ? AW : NEED_W;

	logic [AW-1:0] run_len_q;
	logic [IW-1:0] run_start_q;
	logic [AW-1:0] frag_q;
	logic          found_q;
	logic [IW-1:0] best_start_q;
	logic [AW-1:0] best_len_q;
	logic          fits;
	logic          better;
	logic          take;

	assign fits = (run_len_q != '0) && (CW'(run_len_q) >= CW'(need));
	assign better = best_fit ? (run_len_q < best_len_q) : (run_len_q > best_len_q);
	assign take = fits && (!found_q || better);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len_q <= '0;
			run_start_q <= '0;
			frag_q <= '0;
			found_q <= 1'b0;
			best_start_q <= '0;
			best_len_q <= '0;
		end else if (ctl.clr) begin
			run_len_q <= '0;
			run_start_q <= '0;
			frag_q <= '0;
			found_q <= 1'b0;
			best_start_q <= '0;
			best_len_q <= '0;
		end else if (ctl.step) begin
			if (ctl.free) begin
				if (run_len_q == '0) begin
					run_start_q <= page;
					frag_q <= frag_q + AW'(1);
				end
				run_len_q <= run_len_q + AW'(1);
			end else begin
				if (take) begin
					found_q <= 1'b1;
					best_start_q <= run_start_q;
					best_len_q <= run_len_q;
				end
				run_len_q <= '0;
			end
		end
	end

	assign frag = frag_q;
	assign found = found_q;
	assign best_start = best_start_q;
	assign best_len = best_len_q;

endmodule

/* rtl/best_worst_fit_page_allocator_core.sv */
// page allocator core: command sequencer, page map and result register
//
// channel   direction  handshake                      payload
// command   in         start, accepted when busy low  cmd (cmd_t)
// result    out        done, one cycle, no stall      result (result_t)
// config    in         cfg_we                         cfg_wdata (fit mode)
//
// every command scans the page map once through the single write port owner ram,
// one page a cycle; a successful add then writes its pages one a cycle
// reset clears the fit mode and marks every page free through the used bits
// results leave on done for one cycle; the receiver cannot stall them
module best_worst_fit_page_allocator_core #(
	parameter int TOTAL_PAGES = 32,
	parameter int ID_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  bwfpa_pkg::cmd_t      cmd,
	output logic                 done,
	output bwfpa_pkg::result_t   result,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata
);

	import bwfpa_pkg::*;

	localparam int IW = $clog2(TOTAL_PAGES);
	localparam int AW = $clog2(TOTAL_PAGES + 1);
	localparam int CW = (AW > NEED_W) ? AW : NEED_W;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_FLUSH  = 5'b00100,
		S_DECIDE = 5'b01000,
		S_WRITE  = 5'b10000
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   fit_mode_q;

	logic [1:0]         op_q;
	logic [ID_BITS-1:0] id_q;
	logic [NEED_W-1:0]  need_q;
	logic               zero_q;

	logic [TOTAL_PAGES-1:0] used_q;
	logic [AW-1:0]          addr_q;
	logic                   v_s1;
	logic [IW-1:0]          p_s1;
	logic                   used_s1;
	logic [IW-1:0]          k_q;

	logic               present_q;
	logic               any_q;
	logic [IW-1:0]      kill_first_q;
	logic [AW-1:0]      kill_count_q;
	result_t            result_q;

	logic [ID_BITS-1:0] rd_id;
	logic               issue;
	logic               match;
	logic               accept;
	logic               ram_we;
	logic [IW-1:0]      wr_idx;
	logic [NEED_W-1:0]  need_next;
	logic               last_write;

	scan_ctl_t          sctl;
	logic [AW-1:0]      frag;
	logic               found;
	logic [IW-1:0]      best_start;
	logic [AW-1:0]      best_len;

	assign accept = start && !busy;
	assign issue = (state_q == S_SCAN) && (addr_q != AW'(TOTAL_PAGES));
	assign match = v_s1 && used_s1 && (rd_id == id_q);
	assign wr_idx = IW'(best_start + k_q);
	assign ram_we = (state_q == S_WRITE);
	assign last_write = ((NEED_W'(k_q) + NEED_W'(1)) == need_q);
	assign need_next = NEED_W'((11'(cmd.size_kb) + 11'(KB_ROUND)) >> KB_PER_PAGE_SHIFT);

	always_comb begin
		sctl.clr = accept;
		sctl.step = ((state_q == S_SCAN) && v_s1) || (state_q == S_FLUSH);
		sctl.free = (state_q == S_SCAN) && (!used_s1 || (match && (op_q == OP_KILL)));
	end

	bwfpa_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(TOTAL_PAGES)
	) u_owner_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_idx),
		.wdata(id_q),
		.raddr(addr_q[IW-1:0]),
		.rdata(rd_id)
	);

	bwfpa_scan #(
		.TOTAL_PAGES(TOTAL_PAGES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (sctl),
		.page      (p_s1),
		.need      (need_q),
		.best_fit  (fit_mode_q),
		.frag      (frag),
		.found     (found),
		.best_start(best_start),
		.best_len  (best_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= 1'b0;
		end else if (cfg_we) begin
			fit_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= cmd.operation;
			id_q <= ID_BITS'(cmd.program_id);
			need_q <= need_next;
			zero_q <= (cmd.size_kb == '0);
		end
		p_s1 <= addr_q[IW-1:0];
		used_s1 <= used_q[addr_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			used_q <= '0;
			addr_q <= '0;
			v_s1 <= 1'b0;
			k_q <= '0;
			present_q <= 1'b0;
			any_q <= 1'b0;
			kill_first_q <= '0;
			kill_count_q <= '0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			v_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q <= '0;
						present_q <= 1'b0;
						any_q <= 1'b0;
						kill_first_q <= '0;
						kill_count_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						addr_q <= addr_q + AW'(1);
					end
					if (match) begin
						present_q <= 1'b1;
						if (op_q == OP_KILL) begin
							used_q[p_s1] <= 1'b0;
							kill_count_q <= kill_count_q + AW'(1);
							if (!any_q) begin
								kill_first_q <= p_s1;
							end
							any_q <= 1'b1;
						end
					end
					if (v_s1 && (p_s1 == IW'(TOTAL_PAGES - 1))) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					result_q.status <= ST_QUERY;
					result_q.page_count <= '0;
					result_q.first_page <= '0;
					result_q.free_fragments <= 5'(frag);
					state_q <= S_IDLE;
					done_q <= 1'b1;
					if (op_q == OP_ADD) begin
						if (zero_q) begin
							result_q.status <= ST_ZERO_SIZE;
						end else if (need_q > NEED_W'(MAX_REQ_PAGES)) begin
							result_q.status <= ST_NO_MEM;
						end else if (present_q) begin
							result_q.status <= ST_RUNNING;
						end else if (!found) begin
							result_q.status <= ST_NO_MEM;
						end else begin
							result_q.status <= ST_ADDED;
							result_q.page_count <= need_q;
							result_q.first_page <= 5'(best_start);
							if (CW'(best_len) == CW'(need_q)) begin
								result_q.free_fragments <= 5'(frag - AW'(1));
							end
							k_q <= '0;
							done_q <= 1'b0;
							state_q <= S_WRITE;
						end
					end else if (op_q == OP_KILL) begin
						if (any_q) begin
							result_q.status <= ST_KILLED;
							result_q.page_count <= NEED_W'(kill_count_q);
							result_q.first_page <= 5'(kill_first_q);
						end else begin
							result_q.status <= ST_NOT_FOUND;
						end
					end
				end
				S_WRITE: begin
					used_q[wr_idx] <= 1'b1;
					k_q <= k_q + IW'(1);
					if (last_write) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE) || done_q;
	assign done = done_q;
	assign result = result_q;

`ifndef SYNTH
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command accepted without going busy");

	a_added_pages: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_ADDED)) |-> (result.page_count != '0))
		else $error("add reported without pages");
`endif

endmodule
